// File: hw/rtl/mlfa_pkg.sv
// ----------------------------------------------------------------------------
// mlfa_pkg
// Shared constants, types and helper functions for the frame acker.
// ----------------------------------------------------------------------------
package mlfa_pkg;

    localparam int DEF_BUF_DEPTH = 256;   // frame buffer depth in bytes
    localparam int QUEUE_DEPTH   = 4;     // pending acknowledgements
    localparam int MAGIC_LEN     = 4;
    localparam int HDR_LEN       = 6;
    localparam int ACK_LEN       = 8;
    localparam int LEN_W         = 16;
    localparam int ACK_IDX_W     = $clog2(ACK_LEN);

    localparam logic [7:0] MAGIC_0   = 8'h45;
    localparam logic [7:0] MAGIC_1   = 8'hFF;
    localparam logic [7:0] MAGIC_2   = 8'h7E;
    localparam logic [7:0] MAGIC_3   = 8'hF0;
    localparam logic [7:0] ACK_B4    = 8'h02;
    localparam logic [7:0] ACK_B5    = 8'h00;
    localparam logic [7:0] ACK_B6    = 8'h5A;
    localparam logic [7:0] REPLY_RST = 8'h01;

    // One pending acknowledgement: its reply counter value.
    typedef struct packed {
        logic       vld;
        logic [7:0] counter;
    } ack_evt_t;

    // Queue status toward front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = MAGIC_0;
            2'd1:    b = MAGIC_1;
            2'd2:    b = MAGIC_2;
            default: b = MAGIC_3;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ack_byte(input logic [ACK_IDX_W-1:0] idx,
                                            input logic [7:0]           cntr);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = MAGIC_0;
            3'd1:    b = MAGIC_1;
            3'd2:    b = MAGIC_2;
            3'd3:    b = MAGIC_3;
            3'd4:    b = ACK_B4;
            3'd5:    b = ACK_B5;
            3'd6:    b = ACK_B6;
            default: b = cntr;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/mlfa_front.sv
// ----------------------------------------------------------------------------
// mlfa_front
// Frame parser: tracks byte position, checks magic, assembles the length
// and posts one acknowledgement event per complete frame with matching magic.
// ----------------------------------------------------------------------------
module mlfa_front #(
    parameter int BUF_DEPTH = mlfa_pkg::DEF_BUF_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  mlfa_pkg::q_stat_t  q_stat,
    output mlfa_pkg::ack_evt_t evt
);

    localparam int CW   = $clog2(BUF_DEPTH + 1);
    localparam int SUMW = mlfa_pkg::LEN_W + 1;

    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          mism_reg, mism_next;
    logic [mlfa_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [7:0]                    reply_reg, reply_next;
    logic [CW-1:0]                 pos, cnt1;
    logic                          accept, done;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        // buffer full: this byte starts a new frame
        pos = (cnt_reg >= CW'(BUF_DEPTH)) ? '0 : cnt_reg;
        mism_next = (pos == '0) ? 1'b0 : mism_reg;
        len_next  = len_reg;
        if (pos < CW'(mlfa_pkg::MAGIC_LEN))
        begin
            if (s_tdata != mlfa_pkg::magic_byte(pos[1:0]))
                mism_next = 1'b1;
        end
        else if (pos == CW'(mlfa_pkg::MAGIC_LEN))
            len_next[7:0] = s_tdata;
        else if (pos == CW'(mlfa_pkg::MAGIC_LEN + 1))
            len_next[15:8] = s_tdata;
        cnt1 = pos + CW'(1);

        done       = 1'b0;
        cnt_next   = cnt1;
        reply_next = reply_reg;
        if (cnt1 >= CW'(mlfa_pkg::HDR_LEN))
        begin
            if (mism_next)
                cnt_next = '0;
            else if (SUMW'(cnt1) >= SUMW'(mlfa_pkg::HDR_LEN) + SUMW'(len_next))
            begin
                done       = 1'b1;
                cnt_next   = '0;
                reply_next = reply_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            mism_reg  <= 1'b0;
            len_reg   <= '0;
            reply_reg <= mlfa_pkg::REPLY_RST;
        end
        else if (accept)
        begin
            cnt_reg   <= cnt_next;
            mism_reg  <= mism_next;
            len_reg   <= len_next;
            reply_reg <= reply_next;
        end
    end

    assign evt.vld     = accept && done;
    assign evt.counter = reply_reg;

endmodule

// File: hw/rtl/mlfa_queue.sv
// ----------------------------------------------------------------------------
// mlfa_queue
// Small FIFO of pending acknowledgement counter values.
// ----------------------------------------------------------------------------
module mlfa_queue #(
    parameter int DEPTH = mlfa_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mlfa_pkg::ack_evt_t push,
    input  logic               pop,
    output logic [7:0]         head,
    output mlfa_pkg::q_stat_t  stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [NW-1:0] num_reg, num_next;
    logic          do_push, do_pop;

    assign stat.full  = (num_reg == NW'(DEPTH));
    assign stat.empty = (num_reg == '0);
    assign do_push    = push.vld && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem[rd_reg];

    always_comb
    begin
        wr_next  = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        rd_next  = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        num_next = num_reg;
        if (do_push && !do_pop)
            num_next = num_reg + NW'(1);
        else if (do_pop && !do_push)
            num_next = num_reg - NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push.counter;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            num_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_next;
            if (do_pop)
                rd_reg <= rd_next;
            num_reg <= num_next;
        end
    end

endmodule

// File: hw/rtl/mlfa_back.sv
// ----------------------------------------------------------------------------
// mlfa_back
// Reply serializer: pops one event and sends the 8-byte acknowledgement.
// ----------------------------------------------------------------------------
module mlfa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mlfa_pkg::q_stat_t q_stat,
    input  logic [7:0]        head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);

    localparam int IW = mlfa_pkg::ACK_IDX_W;

    logic          busy_reg;
    logic [IW-1:0] idx_reg;
    logic [7:0]    val_reg;
    logic          last, sent;

    assign last     = (idx_reg == IW'(mlfa_pkg::ACK_LEN - 1));
    assign sent     = busy_reg && m_tready;
    // load a new reply when idle or when the last byte leaves
    assign pop      = !q_stat.empty && (!busy_reg || (sent && last));
    assign m_tvalid = busy_reg;
    assign m_tdata  = mlfa_pkg::ack_byte(idx_reg, val_reg);
    assign m_tlast  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (sent)
        begin
            if (last)
                busy_reg <= 1'b0;
            idx_reg <= idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            val_reg <= head;
    end

endmodule

// File: hw/rtl/magic_length_frame_acker_core.sv
// ----------------------------------------------------------------------------
// magic_length_frame_acker_core
// Finds magic/length framed commands in a byte stream and acknowledges them.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries received bytes, one item per byte. A frame is
//   45 FF 7E F0, a 16-bit little-endian length, then the payload.
//   m_* channel carries acknowledgements: 8 items each,
//   45 FF 7E F0 02 00 5A C, tlast on the final item; C is a reply counter
//   starting at 1 and wrapping mod 256.
//   Throughput: one input item per cycle. The parser takes a byte every
//   cycle as long as the acknowledgement queue (QUEUE_DEPTH entries) has
//   room; the serializer sends one reply byte per cycle while m_tready is
//   high, bursts back to back. The frame's last byte queues its event; the
//   back end loads it when free and then shows the first reply byte.
//   Stall: a stalled receiver holds the current reply byte; parsing goes on
//   until the queue fills, then s_tready drops.
//   Reset: count, length and mismatch flag clear, reply counter becomes 1,
//   queue empties; no reply is pending.
// ----------------------------------------------------------------------------
module magic_length_frame_acker_core #(
    parameter int BUF_DEPTH   = mlfa_pkg::DEF_BUF_DEPTH,
    parameter int QUEUE_DEPTH = mlfa_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] tx_byte
    output logic       m_tlast    // tx_last
);

    mlfa_pkg::ack_evt_t evt;
    mlfa_pkg::q_stat_t  q_stat;
    logic [7:0]         head;
    logic               pop;

    // front end: parse and classify each byte
    mlfa_front #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .evt      (evt)
    );

    // pending replies
    mlfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (evt),
        .pop   (pop),
        .head  (head),
        .stat  (q_stat)
    );

    // back end: serialize replies
    mlfa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
